FILE: sv/mbdrf_pkg.sv
// shared types and constants of the macroblock decoder register front end
package mbdrf_pkg;

    localparam int TABLE_ENTRIES_DEFAULT = 64;
    localparam int DATA_W = 32;
    localparam int COUNT_W = 16;
    localparam int CMD_W = 3;
    localparam int DEPTH_W = 2;
    localparam int BLOCK_W = 3;

    // command codes
    localparam logic [CMD_W-1:0] CMD_DECODE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_QUANT = 3'd2;
    localparam logic [CMD_W-1:0] CMD_SCALE = 3'd3;

    // parameter word counts
    localparam logic [COUNT_W-1:0] QUANT_WORDS_SHORT = 16'd16;
    localparam logic [COUNT_W-1:0] QUANT_WORDS_LONG = 16'd32;
    localparam logic [COUNT_W-1:0] SCALE_WORDS = 16'd32;
    localparam logic [COUNT_W-1:0] QUANT_LUMA_WORDS = 16'd16;

    // block code after reset: chroma red block
    localparam logic [BLOCK_W-1:0] BLOCK_CODE_RESET = 3'd4;

    // port codes
    localparam logic PORT_DATA = 1'b0;
    localparam logic PORT_STATUS = 1'b1;
    localparam logic REQ_READ = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    typedef struct packed {
        logic                luma_we;
        logic                chroma_we;
        logic                scale_we;
        logic [COUNT_W-1:0]  word_idx;
        logic [DATA_W-1:0]   data;
    } tbl_wr_t;

endpackage

FILE: sv/mbdrf_req_if.sv
// bus access channel: one transaction per register access
interface mbdrf_req_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic        port_select;
    logic [31:0] write_data;

    modport source (output valid, output req_type, output port_select, output write_data,
                    input ready);
    modport sink (input valid, input req_type, input port_select, input write_data,
                  output ready);
endinterface

FILE: sv/mbdrf_rsp_if.sv
// read data channel: one transaction per register access
interface mbdrf_rsp_if;
    logic        valid;
    logic        ready;
    logic [31:0] read_data;

    modport source (output valid, output read_data, input ready);
    modport sink (input valid, input read_data, output ready);
endinterface

FILE: sv/mbdrf_tables.sv
// quant and scale table memories, written one parameter word per cycle
module mbdrf_tables #(
    parameter int TABLE_ENTRIES = mbdrf_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  logic              clk,
    input  mbdrf_pkg::tbl_wr_t tbl_wr
);
    import mbdrf_pkg::*;

    // luma rows then chroma rows, four byte entries per row
    localparam int QUANT_ROWS = 2 * (TABLE_ENTRIES / 4);
    localparam int SCALE_ROWS = TABLE_ENTRIES / 2;
    localparam int QROW_W = $clog2(QUANT_ROWS);
    localparam int SROW_W = $clog2(SCALE_ROWS);

    // quant row index equals the parameter word index: chroma words follow luma words
    logic [DATA_W-1:0] quant_mem [QUANT_ROWS];
    // two halfword entries per scale row
    logic [DATA_W-1:0] scale_mem [SCALE_ROWS];

    always_ff @(posedge clk)
    begin
        if (tbl_wr.luma_we || tbl_wr.chroma_we)
        begin
            quant_mem[tbl_wr.word_idx[QROW_W-1:0]] <= tbl_wr.data;
        end
        if (tbl_wr.scale_we)
        begin
            scale_mem[tbl_wr.word_idx[SROW_W-1:0]] <= tbl_wr.data;
        end
    end

endmodule

FILE: sv/mbdrf_regs.sv
// command decode, parameter counters, control bits and status packing
module mbdrf_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           acc,
    input  logic                           req_type,
    input  logic                           port_select,
    input  logic [mbdrf_pkg::DATA_W-1:0]   write_data,
    output logic [mbdrf_pkg::DATA_W-1:0]   result,
    output mbdrf_pkg::tbl_wr_t             tbl_wr
);
    import mbdrf_pkg::*;

    logic [CMD_W-1:0]   current_command_reg, current_command_next;
    logic [COUNT_W-1:0] words_received_reg, words_received_next;
    logic [COUNT_W-1:0] words_expected_reg, words_expected_next;
    logic               input_enable_reg, input_enable_next;
    logic               output_enable_reg, output_enable_next;
    logic [DEPTH_W-1:0] pixel_depth_reg, pixel_depth_next;
    logic               signed_output_reg, signed_output_next;
    logic               set_bit_fifteen_reg, set_bit_fifteen_next;
    logic [BLOCK_W-1:0] block_code_reg, block_code_next;

    logic               pending;
    logic [CMD_W-1:0]   cmd;
    logic [DATA_W-1:0]  status;
    logic [COUNT_W-1:0] remaining;

    assign pending = words_received_reg != words_expected_reg;
    assign cmd = write_data[31:29];
    assign remaining = words_expected_reg - words_received_reg;

    assign status = {1'b1, 1'b0, pending, input_enable_reg, output_enable_reg,
                     pixel_depth_reg, signed_output_reg, set_bit_fifteen_reg,
                     4'b0000, block_code_reg, remaining};

    always_comb
    begin
        current_command_next = current_command_reg;
        words_received_next = words_received_reg;
        words_expected_next = words_expected_reg;
        input_enable_next = input_enable_reg;
        output_enable_next = output_enable_reg;
        pixel_depth_next = pixel_depth_reg;
        signed_output_next = signed_output_reg;
        set_bit_fifteen_next = set_bit_fifteen_reg;
        block_code_next = block_code_reg;
        result = '0;
        tbl_wr.luma_we = 1'b0;
        tbl_wr.chroma_we = 1'b0;
        tbl_wr.scale_we = 1'b0;
        tbl_wr.word_idx = words_received_reg;
        tbl_wr.data = write_data;

        if (acc)
        begin
            if (req_type == REQ_READ)
            begin
                if (port_select == PORT_STATUS)
                begin
                    result = status;
                end
            end
            else if (port_select == PORT_DATA)
            begin
                if (!pending)
                begin
                    // new command word, format bits taken for every code
                    current_command_next = cmd;
                    pixel_depth_next = write_data[28:27];
                    signed_output_next = write_data[26];
                    set_bit_fifteen_next = write_data[25];
                    case (cmd)
                        CMD_DECODE:
                        begin
                            words_received_next = '0;
                            words_expected_next = write_data[15:0];
                        end
                        CMD_QUANT:
                        begin
                            words_received_next = '0;
                            words_expected_next = write_data[0] ? QUANT_WORDS_LONG
                                                                : QUANT_WORDS_SHORT;
                        end
                        CMD_SCALE:
                        begin
                            words_received_next = '0;
                            words_expected_next = SCALE_WORDS;
                        end
                        default:
                        begin
                            // unknown code: counters kept
                        end
                    endcase
                end
                else
                begin
                    case (current_command_reg)
                        CMD_QUANT:
                        begin
                            tbl_wr.luma_we = words_received_reg < QUANT_LUMA_WORDS;
                            tbl_wr.chroma_we = !(words_received_reg < QUANT_LUMA_WORDS);
                        end
                        CMD_SCALE:
                        begin
                            tbl_wr.scale_we = 1'b1;
                        end
                        default:
                        begin
                            // decode parameters are counted only
                        end
                    endcase
                    words_received_next = words_received_reg + 16'd1;
                end
            end
            else if (write_data[31])
            begin
                words_received_next = '0;
                words_expected_next = '0;
                input_enable_next = 1'b0;
                output_enable_next = 1'b0;
                pixel_depth_next = '0;
                signed_output_next = 1'b0;
                set_bit_fifteen_next = 1'b0;
                block_code_next = BLOCK_CODE_RESET;
            end
            else
            begin
                input_enable_next = write_data[30];
                output_enable_next = write_data[29];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            current_command_reg <= '0;
            words_received_reg <= '0;
            words_expected_reg <= '0;
            input_enable_reg <= 1'b0;
            output_enable_reg <= 1'b0;
            pixel_depth_reg <= '0;
            signed_output_reg <= 1'b0;
            set_bit_fifteen_reg <= 1'b0;
            block_code_reg <= BLOCK_CODE_RESET;
        end
        else
        begin
            current_command_reg <= current_command_next;
            words_received_reg <= words_received_next;
            words_expected_reg <= words_expected_next;
            input_enable_reg <= input_enable_next;
            output_enable_reg <= output_enable_next;
            pixel_depth_reg <= pixel_depth_next;
            signed_output_reg <= signed_output_next;
            set_bit_fifteen_reg <= set_bit_fifteen_next;
            block_code_reg <= block_code_next;
        end
    end

`ifndef SYNTHESIS
    a_param_counts: assert property (@(posedge clk) disable iff (!rst_n)
        acc && req_type == REQ_WRITE && port_select == PORT_DATA && pending
        |=> words_received_reg == $past(words_received_reg) + 16'd1)
        else $error("parameter word not counted");

    a_ctrl_reset: assert property (@(posedge clk) disable iff (!rst_n)
        acc && req_type == REQ_WRITE && port_select == PORT_STATUS && write_data[31]
        |=> !pending && block_code_reg == BLOCK_CODE_RESET && !input_enable_reg)
        else $error("control reset incomplete");

    a_quant_count: assert property (@(posedge clk) disable iff (!rst_n)
        acc && req_type == REQ_WRITE && port_select == PORT_DATA && !pending
        && cmd == CMD_QUANT
        |=> words_received_reg == '0
            && (words_expected_reg == QUANT_WORDS_SHORT
                || words_expected_reg == QUANT_WORDS_LONG))
        else $error("bad quant table word count");
`endif

endmodule

FILE: sv/macroblock_decoder_register_front_unit.sv
// top level of the macroblock decoder register front end
// Register front end of a macroblock decoder. Each req transaction is one bus
// access (read or write, data/command port or status/control port) and yields
// exactly one rsp transaction carrying the read word: the status word for a
// status port read, zero otherwise. Accesses are taken one per clock while the
// output register is free or drains; the result is registered in the cycle
// after acceptance, and a new access is accepted in the same cycle as the
// previous result is taken, so throughput is one access per cycle while rsp
// is ready. The status word reflects every access accepted before it. Quant
// and scale tables are held in write-only memories, one parameter word written
// per cycle while accesses are accepted, and need no clearing pass after reset.
module macroblock_decoder_register_front_unit #(
    parameter int TABLE_ENTRIES = mbdrf_pkg::TABLE_ENTRIES_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    mbdrf_req_if.sink   req,
    mbdrf_rsp_if.source rsp
);
    import mbdrf_pkg::*;

    // output register state
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] read_data_reg;

    // handshake and decoded access
    logic              acc;
    logic [DATA_W-1:0] result;
    tbl_wr_t           tbl_wr;

    // accept whenever the output register is free or drains this cycle
    assign req.ready = !out_valid_reg || rsp.ready;
    assign acc = req.valid && req.ready;

    // command decode, counters and status packing
    mbdrf_regs u_regs (
        .clk         (clk),
        .rst_n       (rst_n),
        .acc         (acc),
        .req_type    (req.req_type),
        .port_select (req.port_select),
        .write_data  (req.write_data),
        .result      (result),
        .tbl_wr      (tbl_wr)
    );

    // parameter table storage
    mbdrf_tables #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_tables (
        .clk    (clk),
        .tbl_wr (tbl_wr)
    );

    // output register: filled on acceptance, emptied when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (acc)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // read data payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            read_data_reg <= result;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.read_data = read_data_reg;

`ifndef SYNTHESIS
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> rsp.valid)
        else $error("accepted access produced no result");

    a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
        acc && (req.req_type == REQ_WRITE || req.port_select == PORT_DATA)
        |=> rsp.read_data == '0)
        else $error("nonzero read data for write or data port access");

    a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.read_data))
        else $error("waiting result changed or dropped");
`endif

endmodule
